// ===== design/peer_table_with_liveness_assert.svh =====
// Assertion macros for the peer table checks
`ifndef PEER_TABLE_WITH_LIVENESS_ASSERT_SVH
`define PEER_TABLE_WITH_LIVENESS_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define PTL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("peer table check failed");

// Antecedent implies consequent in the next cycle
`define PTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("peer table check failed");

`endif

// ===== design/ptl_pkg.sv =====
// Shared types and constants of the peer table
`timescale 1ns / 1ps

package ptl_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int MESSAGE_BYTES = 244;
    localparam int MAX_RESULTS   = 16;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] TIMEOUT_RESET  = 32'd60000;
    localparam logic [7:0]  SENSOR_MIN_LEN = 8'd8;

    // request types
    localparam logic [1:0] REQ_FRAME  = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SWEEP  = 2'd2;

    // message types
    localparam logic [1:0] MSG_PAIR  = 2'd0;
    localparam logic [1:0] MSG_DATA  = 2'd1;
    localparam logic [1:0] MSG_ECHO  = 2'd2;
    localparam logic [1:0] MSG_OTHER = 2'd3;

    // peer kinds that carry data
    localparam logic [2:0] KIND_SENSOR = 3'd1;
    localparam logic [2:0] KIND_SWITCH = 3'd2;
    localparam logic [2:0] KIND_DIMMER = 3'd4;

    // config register indexes
    localparam logic CFG_PAIR_EN = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [3:0] {
        STAT_PAIRED    = 4'd0,
        STAT_DATA      = 4'd1,
        STAT_PONG      = 4'd2,
        STAT_REMOVED   = 4'd3,
        STAT_OFFLINE   = 4'd4,
        STAT_NONE      = 4'd5,
        STAT_SHORT     = 4'd6,
        STAT_PAIR_OFF  = 4'd7,
        STAT_FULL      = 4'd8,
        STAT_DUP       = 4'd9,
        STAT_UNK_PEER  = 4'd10,
        STAT_UNK_TYPE  = 4'd11
    } t_status;

    typedef enum logic [1:0] {
        REP_NONE = 2'd0,
        REP_ACK  = 2'd1,
        REP_PONG = 2'd2
    } t_reply;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SHIFT,
        ST_SWEEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  frame_length;
        logic [1:0]  msg_type;
        logic [2:0]  client_kind;
        logic [47:0] peer_mac;
        logic [7:0]  payload_len;
        logic [63:0] payload_low;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [47:0] mac;
        logic [2:0]  kind;
        logic        online;
        logic [31:0] last_seen;
        logic [63:0] sensor_raw;
        logic        switch_on;
        logic [7:0]  dimmer;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_cmd;

    typedef struct packed {
        logic mac_eq;
        logic stale;
    } t_cmp_res;

    typedef struct packed {
        t_status    status;
        logic [3:0] entry_index;
        t_reply     reply_kind;
        logic       last_result;
    } t_result;

endpackage

// ===== design/ptl_table.sv =====
// Peer entry memory: one write port, one registered read port
`timescale 1ns / 1ps

module ptl_table import ptl_pkg::*; (
    input  logic     i_clk,
    input  t_mem_cmd i_cmd,
    output t_entry   o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ptl_cmp.sv =====
// Shared compare unit: MAC match and staleness test for one entry
`timescale 1ns / 1ps

module ptl_cmp import ptl_pkg::*; (
    input  logic [47:0] i_mac_a,
    input  logic [47:0] i_mac_b,
    input  logic [31:0] i_now,
    input  logic [31:0] i_last_seen,
    input  logic [31:0] i_timeout,
    output t_cmp_res    o_res
);

    logic [31:0] age;

    // age wraps modulo 2^32 with the time base
    assign age          = i_now - i_last_seen;
    assign o_res.mac_eq = (i_mac_a == i_mac_b);
    assign o_res.stale  = (age > i_timeout);

endmodule

// ===== design/ptl_ctrl.sv =====
// Sequencer walks 1 entry/cycle: lookup, compaction, sweep (holds if output full)
`timescale 1ns / 1ps

module ptl_ctrl import ptl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_req             i_req,
    input  logic             i_pair_en,
    input  logic             i_slot_free,
    input  t_entry           i_rd_entry,
    input  t_cmp_res         i_cmp,
    output logic             o_ready,
    output logic [47:0]      o_cur_mac,
    output logic [31:0]      o_cur_now,
    output t_mem_cmd         o_mem,
    output logic             o_emit_valid,
    output t_result          o_emit,
    output logic [CNT_W-1:0] o_count
);

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    t_result          r_res, n_res;
    logic             r_pend_v, n_pend_v;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [RES_W-1:0] r_nres, n_nres;
    logic [IDX_W-1:0] r_hit, n_hit;

    logic [CNT_W-1:0] idx_p1, idx_p2;
    logic [IDX_W-1:0] idx_low;
    t_entry           upd_entry, new_entry, off_entry;

    function automatic t_result mk_res(t_status st, logic [IDX_W-1:0] idx, t_reply rp,
                                       logic last);
        t_result r;
        r.status      = st;
        r.entry_index = 4'(idx);
        r.reply_kind  = rp;
        r.last_result = last;
        return r;
    endfunction

    function automatic t_entry apply_update(t_entry e, t_req q);
        t_entry r;
        r = e;
        if (q.msg_type == MSG_DATA) begin
            case (e.kind)
                KIND_SENSOR: begin
                    if (q.payload_len >= SENSOR_MIN_LEN) r.sensor_raw = q.payload_low;
                end
                KIND_SWITCH: begin
                    if (q.payload_len != 8'd0) r.switch_on = (q.payload_low[7:0] != 8'd0);
                end
                KIND_DIMMER: begin
                    if (q.payload_len != 8'd0) r.dimmer = q.payload_low[7:0];
                end
                default: begin
                end
            endcase
        end
        r.last_seen = q.now_ms;
        r.online    = 1'b1;
        return r;
    endfunction

    assign idx_p1  = CNT_W'(r_idx + 1'b1);
    assign idx_p2  = CNT_W'(r_idx + 2'd2);
    assign idx_low = r_idx[IDX_W-1:0];

    assign upd_entry = apply_update(i_rd_entry, r_req);

    always_comb begin
        new_entry            = '0;
        new_entry.mac        = r_req.peer_mac;
        new_entry.kind       = r_req.client_kind;
        new_entry.online     = 1'b1;
        new_entry.last_seen  = r_req.now_ms;
        off_entry            = i_rd_entry;
        off_entry.online     = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_res      <= n_res;
        r_pend_idx <= n_pend_idx;
        r_nres     <= n_nres;
        r_hit      <= n_hit;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res        = r_res;
        n_pend_v     = r_pend_v;
        n_pend_idx   = r_pend_idx;
        n_nres       = r_nres;
        n_hit        = r_hit;
        o_ready      = 1'b0;
        o_emit_valid = 1'b0;
        o_emit       = r_res;
        o_mem.we     = 1'b0;
        o_mem.waddr  = idx_low;
        o_mem.wdata  = i_rd_entry;
        o_mem.raddr  = idx_p1[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_mem.raddr = '0;
                if (i_valid) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_nres   = '0;
                    n_pend_v = 1'b0;
                    case (i_req.req_type)
                        REQ_SWEEP:  n_state = ST_SWEEP;
                        REQ_REMOVE: n_state = ST_LOOK;
                        REQ_FRAME: begin
                            if (i_req.frame_length < 8'(MESSAGE_BYTES)) begin
                                n_res   = mk_res(STAT_SHORT, '0, REP_NONE, 1'b1);
                                n_state = ST_EMIT;
                            end else begin
                                case (i_req.msg_type)
                                    MSG_PAIR: begin
                                        if (!i_pair_en) begin
                                            n_res   = mk_res(STAT_PAIR_OFF, '0, REP_NONE, 1'b1);
                                            n_state = ST_EMIT;
                                        end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                            n_res   = mk_res(STAT_FULL, '0, REP_NONE, 1'b1);
                                            n_state = ST_EMIT;
                                        end else begin
                                            n_state = ST_LOOK;
                                        end
                                    end
                                    MSG_OTHER: begin
                                        n_res   = mk_res(STAT_UNK_TYPE, '0, REP_NONE, 1'b1);
                                        n_state = ST_EMIT;
                                    end
                                    default: n_state = ST_LOOK;
                                endcase
                            end
                        end
                        default: begin
                            n_res   = mk_res(STAT_UNK_TYPE, '0, REP_NONE, 1'b1);
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end

            // read data holds entry r_idx; next address goes out each cycle
            ST_LOOK: begin
                if (r_idx >= r_count) begin
                    if (r_req.req_type == REQ_FRAME && r_req.msg_type == MSG_PAIR) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_count[IDX_W-1:0];
                        o_mem.wdata = new_entry;
                        n_count     = CNT_W'(r_count + 1'b1);
                        n_res       = mk_res(STAT_PAIRED, r_count[IDX_W-1:0], REP_ACK, 1'b1);
                    end else begin
                        n_res = mk_res(STAT_UNK_PEER, '0, REP_NONE, 1'b1);
                    end
                    n_state = ST_EMIT;
                end else if (i_cmp.mac_eq) begin
                    if (r_req.req_type == REQ_REMOVE) begin
                        n_hit   = idx_low;
                        n_state = ST_SHIFT;
                    end else if (r_req.msg_type == MSG_PAIR) begin
                        n_res   = mk_res(STAT_DUP, idx_low, REP_NONE, 1'b1);
                        n_state = ST_EMIT;
                    end else begin
                        o_mem.we    = 1'b1;
                        o_mem.wdata = upd_entry;
                        if (r_req.msg_type == MSG_DATA) begin
                            n_res = mk_res(STAT_DATA, idx_low, REP_NONE, 1'b1);
                        end else begin
                            n_res = mk_res(STAT_PONG, idx_low, REP_PONG, 1'b1);
                        end
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_idx = idx_p1;
                end
            end

            // read data holds entry r_idx+1, copied down to r_idx
            ST_SHIFT: begin
                if (idx_p1 < r_count) begin
                    o_mem.we    = 1'b1;
                    o_mem.raddr = idx_p2[IDX_W-1:0];
                    n_idx       = idx_p1;
                end else begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_res   = mk_res(STAT_REMOVED, r_hit, REP_NONE, 1'b1);
                    n_state = ST_EMIT;
                end
            end

            // a stale hit is held back until the next one or the end of the
            // walk shows whether it is the final beat
            ST_SWEEP: begin
                if (r_idx >= r_count || r_nres == RES_W'(MAX_RESULTS)) begin
                    if (r_pend_v) begin
                        n_res = mk_res(STAT_OFFLINE, r_pend_idx, REP_NONE, 1'b1);
                    end else begin
                        n_res = mk_res(STAT_NONE, '0, REP_NONE, 1'b1);
                    end
                    n_state = ST_EMIT;
                end else if (i_rd_entry.online && i_cmp.stale) begin
                    if (r_pend_v && !i_slot_free) begin
                        o_mem.raddr = idx_low;
                    end else begin
                        if (r_pend_v) begin
                            o_emit_valid = 1'b1;
                            o_emit       = mk_res(STAT_OFFLINE, r_pend_idx, REP_NONE, 1'b0);
                        end
                        o_mem.we    = 1'b1;
                        o_mem.wdata = off_entry;
                        n_pend_v    = 1'b1;
                        n_pend_idx  = idx_low;
                        n_nres      = RES_W'(r_nres + 1'b1);
                        n_idx       = idx_p1;
                    end
                end else begin
                    n_idx = idx_p1;
                end
            end

            ST_EMIT: begin
                if (i_slot_free) begin
                    o_emit_valid = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cur_mac = r_req.peer_mac;
    assign o_cur_now = r_req.now_ms;
    assign o_count   = r_count;

endmodule

// ===== design/peer_table_with_liveness.sv =====
// Peer table with liveness: a rejected item goes straight to its result; a lookup, a
// remove or a sweep walks the table first. Each loads its final beat into the output
// register once that register is free. Ready returns the cycle after the final beat is
// loaded; the table walks one entry a cycle, but a sweep holds while the output is full.
// Reset (synchronous, active low) clears the entry count, the output valid flag and the
// config (pairing off, timeout 60000 ms); table contents are left as they are.
`timescale 1ns / 1ps

`include "peer_table_with_liveness_assert.svh"

module peer_table_with_liveness import ptl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_frame_length,
    input  logic [1:0]  i_msg_type,
    input  logic [2:0]  i_client_kind,
    input  logic [47:0] i_peer_mac,
    input  logic [7:0]  i_payload_len,
    input  logic [63:0] i_payload_low,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [3:0]  o_entry_index,
    output logic [1:0]  o_reply_kind,
    output logic        o_last_result
);

    logic             r_pair_en;
    logic [31:0]      r_timeout;
    logic             r_out_v;
    t_result          r_out;

    t_req             req;
    t_entry           rd_entry;
    t_cmp_res         cmp_res;
    t_mem_cmd         mem_cmd;
    t_result          emit;
    logic             emit_valid;
    logic             slot_free;
    logic [47:0]      cur_mac;
    logic [31:0]      cur_now;
    logic [CNT_W-1:0] count;

    assign req.req_type     = i_req_type;
    assign req.frame_length = i_frame_length;
    assign req.msg_type     = i_msg_type;
    assign req.client_kind  = i_client_kind;
    assign req.peer_mac     = i_peer_mac;
    assign req.payload_len  = i_payload_len;
    assign req.payload_low  = i_payload_low;
    assign req.now_ms       = i_now_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_en <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_PAIR_EN: r_pair_en <= i_cfg_wdata[0];
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // output register parts the sequencer from the result side
    assign slot_free = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit_valid) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid) begin
            r_out <= emit;
        end
    end

    ptl_table u_table (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (rd_entry)
    );

    ptl_cmp u_cmp (
        .i_mac_a     (cur_mac),
        .i_mac_b     (rd_entry.mac),
        .i_now       (cur_now),
        .i_last_seen (rd_entry.last_seen),
        .i_timeout   (r_timeout),
        .o_res       (cmp_res)
    );

    ptl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_req        (req),
        .i_pair_en    (r_pair_en),
        .i_slot_free  (slot_free),
        .i_rd_entry   (rd_entry),
        .i_cmp        (cmp_res),
        .o_ready      (o_ready),
        .o_cur_mac    (cur_mac),
        .o_cur_now    (cur_now),
        .o_mem        (mem_cmd),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .o_count      (count)
    );

    assign o_valid       = r_out_v;
    assign o_status      = r_out.status;
    assign o_entry_index = r_out.entry_index;
    assign o_reply_kind  = r_out.reply_kind;
    assign o_last_result = r_out.last_result;

    `PTL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, count <= CNT_W'(TABLE_DEPTH))
    `PTL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `PTL_ASSERT_NOW(a_emit_into_free_slot, i_clk, i_rst_n, emit_valid, slot_free)

endmodule
